/* src/wips_pkg.sv */
// ----------------------------------------------------------------------------
// wips_pkg
// Shared types, constants and the sort-key compare for the priority sorter.
// ----------------------------------------------------------------------------
package wips_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int INDEX_W       = 16;
    localparam int POINTS_W      = 32;

    typedef struct packed {
        logic                fast;
        logic [POINTS_W-1:0] points;
        logic [INDEX_W-1:0]  index;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // insert new item into the sorted chain
        logic pop;   // shift chain toward cell 0 by one
    } cell_cmd_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // true when a sorts strictly ahead of b
    function automatic logic goes_before(input entry_t a, input entry_t b);
        logic res;
        if (a.fast != b.fast)
        begin
            res = !a.fast;
        end
        else if (a.points != b.points)
        begin
            res = (a.points > b.points);
        end
        else
        begin
            res = (a.index < b.index);
        end
        return res;
    endfunction

endpackage

/* src/work_item_priority_sorter_top.sv */
// ----------------------------------------------------------------------------
// work_item_priority_sorter_top
// Stable batch sort of work items by (fast flag, point count, index).
// ----------------------------------------------------------------------------
// Items are loaded one per cycle into a chain of MAX_ITEMS sorting cells, each
// insertion landing in its sorted place at the edge that accepts it. The item
// with batch_end closes the batch; the block then holds off input and sends
// the n stored indices out of cell 0 in order, one per cycle while out_stall
// is low. Items arriving with the chain full are dropped and every result of
// that batch has overflowed set. A new batch can load while the last result
// still sits in the output register.
module work_item_priority_sorter_top
    import wips_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [INDEX_W-1:0]  item_index,
    input  logic [POINTS_W-1:0] point_count,
    input  logic                fast_path,
    input  logic                batch_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [INDEX_W-1:0]  ordered_index,
    output logic                order_end,
    output logic                overflowed
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] ordered_index_reg;
    logic               order_end_reg;
    logic               overflowed_reg;

    logic      in_acc;
    logic      full;
    logic      pop;
    logic      last_pop;
    cell_cmd_t cmd;
    entry_t    new_entry;
    entry_t    cell_entry [MAX_ITEMS];
    logic      cell_before [MAX_ITEMS];

    assign new_entry = '{fast: fast_path, points: point_count, index: item_index};
    assign in_stall  = (state_reg == ST_EMIT);
    assign in_acc    = in_valid && !in_stall;
    assign full      = (count_reg == CNT_W'(MAX_ITEMS));
    assign pop       = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign last_pop  = pop && (count_reg == CNT_W'(1));

    assign cmd.ins = in_acc && !full;
    assign cmd.pop = pop;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_b;
            if (g == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_b = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[g-1];
                assign left_b = cell_before[g-1];
            end
            if (g == MAX_ITEMS - 1)
            begin : g_last
                assign right_e = cell_entry[g];
            end
            else
            begin : g_inner
                assign right_e = cell_entry[g+1];
            end
            wips_cell #(
                .CNT_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .count       (count_reg),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_before (left_b),
                .right_entry (right_e),
                .entry       (cell_entry[g]),
                .ahead       (cell_before[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (batch_end)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (pop)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    if (last_pop)
                    begin
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ordered_index_reg <= cell_entry[0].index;
            order_end_reg     <= last_pop;
            overflowed_reg    <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ordered_index = ordered_index_reg;
    assign order_end     = order_end_reg;
    assign overflowed    = overflowed_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (count_reg != '0))
        else $error("emitting from an empty chain");

    a_close_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && batch_end) |=> (state_reg == ST_EMIT))
        else $error("closing item did not start emission");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        last_pop |=> (count_reg == '0) && !ovf_reg && out_valid && order_end)
        else $error("last result did not end the batch cleanly");

endmodule

/* src/wips_cell.sv */
// ----------------------------------------------------------------------------
// wips_cell
// One slot of the sorted chain: compares the incoming item with its own entry,
// shifts away from cell 0 on insert and toward cell 0 on pop.
// ----------------------------------------------------------------------------
module wips_cell
    import wips_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
)
(
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic [CNT_W-1:0] count,
    input  entry_t           new_entry,
    input  entry_t           left_entry,
    input  logic             left_before,
    input  entry_t           right_entry,
    output entry_t           entry,
    output logic             ahead
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    // slots at or beyond the fill count are empty and accept anything
    assign occupied = (count > CNT_W'(IDX));
    assign ahead    = !occupied || goes_before(new_entry, entry_reg);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.pop)
        begin
            entry_next = right_entry;
        end
        else if (cmd.ins && ahead)
        begin
            entry_next = left_before ? left_entry : new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
